/* hdl/nws_pkg.sv */
// Shared types, widths and the sigmoid lookup table for the neuron datapath.
`default_nettype none
package nws_pkg;

	// Field and datapath widths
	localparam int VALUE_W    = 16;            // Q4.12 source and weight
	localparam int FRAC_W     = 12;
	localparam int TERM_W     = 2 * VALUE_W;   // product or shifted bias weight
	localparam int ACC_W      = 40;            // Q16.24 accumulator
	localparam int OUT_W      = 24;            // Q12.12 results
	localparam int SIG_W      = FRAC_W + 1;    // table entries span 0..4096
	localparam int TABLE_N    = 256;
	localparam int TABLE_HALF = TABLE_N / 2;
	localparam int TABLE_AW   = 8;
	localparam int QUEUE_N    = 4;
	localparam int QUEUE_AW   = 2;

	// Activation mode register codes
	localparam logic MODE_SIGMOID  = 1'b0;
	localparam logic MODE_IDENTITY = 1'b1;

	// Exponential step e^(-1/16) in Q0.32
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	// One link term passed from the front end to the accumulator
	typedef struct packed {
		logic                     last;
		logic signed [TERM_W-1:0] term;
	} link_term_t;

	typedef logic [SIG_W-1:0] sig_tab_t [TABLE_N];

	// Shift-and-subtract unsigned divide, only evaluated while building the table
	function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Built at elaboration: entry i covers x = (i-128)/16 up to the next step
	function automatic sig_tab_t build_sig_table();
		sig_tab_t    tab;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] s [TABLE_HALF + 1];
		e = 64'd1 << 32;
		for (int k = 0; k <= TABLE_HALF; k++) begin
			d = (64'd1 << 32) + e;
			s[k] = long_div((64'd1 << (FRAC_W + 32)) + (d >> 1), d);
			e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		for (int k = 0; k < TABLE_N; k++) begin
			if (k >= TABLE_HALF)
				tab[k] = s[k - TABLE_HALF][SIG_W-1:0];
			else
				tab[k] = SIG_W'((64'd1 << FRAC_W) - s[TABLE_HALF - k]);
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

/* hdl/nws_front.sv */
// Front end: accepts link items and forms the per-link term in a registered stage.
`default_nettype none
module nws_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [nws_pkg::VALUE_W-1:0] source_value,
	input  wire logic signed [nws_pkg::VALUE_W-1:0] link_weight,
	input  wire logic                           is_bias,
	input  wire logic                           last_link,
	output logic                                term_valid,
	input  wire logic                           term_ready,
	output nws_pkg::link_term_t                 term_item
);
	import nws_pkg::*;

	logic                     valid_s1;
	link_term_t               item_s1;
	logic signed [TERM_W-1:0] term_d;

	// Bias links add the weight scaled to product scale; others add src * w
	always_comb begin
		if (is_bias)
			term_d = TERM_W'(link_weight) <<< FRAC_W;
		else
			term_d = TERM_W'(source_value) * TERM_W'(link_weight);
	end

	assign in_ready   = !valid_s1 || term_ready;
	assign term_valid = valid_s1;
	assign term_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.term <= term_d;
			item_s1.last <= last_link;
		end
	end

endmodule
`default_nettype wire

/* hdl/nws_queue.sv */
// Short FIFO that decouples the term front end from the accumulator.
`default_nettype none
module nws_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire nws_pkg::link_term_t push_item,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output nws_pkg::link_term_t      pop_item
);
	import nws_pkg::*;

	link_term_t          entry_q [QUEUE_N];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_N));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

/* hdl/nws_back.sv */
// Back end: saturating accumulation, final rounding, activation and output register.
`default_nettype none
module nws_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       act_mode,
	input  wire logic                       term_valid,
	output logic                            term_ready,
	input  wire nws_pkg::link_term_t        term_item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [nws_pkg::OUT_W-1:0] weighted_sum,
	output logic signed [nws_pkg::OUT_W-1:0] activation
);
	import nws_pkg::*;

	localparam int RND_W = ACC_W + 1;
	localparam int SHF_W = RND_W - FRAC_W;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  fin_q;
	logic                     fin_valid_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  sum_q;
	logic signed [OUT_W-1:0]  act_q;

	logic signed [RND_W-1:0]  acc_wide;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     out_free;
	logic                     fin_free;
	logic                     pop;

	logic signed [RND_W-1:0]  rnd;
	logic signed [SHF_W-1:0]  shf;
	logic signed [OUT_W-1:0]  sum_d;
	logic signed [OUT_W-1:0]  act_d;
	logic [TABLE_AW-1:0]      sig_idx;
	logic [SIG_W-1:0]         sig_val;

	// Saturating accumulate
	always_comb begin
		acc_wide = RND_W'(acc_q) + RND_W'(term_item.term);
		if (acc_wide[RND_W-1] != acc_wide[RND_W-2])
			acc_next = acc_wide[RND_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
			                             : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_next = acc_wide[ACC_W-1:0];
	end

	// Handshake between accumulator, final stage and output register
	assign out_free   = !out_valid_q || out_ready;
	assign fin_free   = !fin_valid_q || out_free;
	assign term_ready = !term_item.last || fin_free;
	assign pop        = term_valid && term_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			fin_valid_q <= 1'b0;
		end else begin
			if (pop)
				acc_q <= term_item.last ? '0 : acc_next;
			if (fin_free)
				fin_valid_q <= pop && term_item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && term_item.last && fin_free)
			fin_q <= acc_next;
	end

	// Round half up to Q12.12 and saturate to 24 bits
	always_comb begin
		rnd = RND_W'(fin_q) + RND_W'(1 << (FRAC_W - 1));
		shf = rnd[RND_W-1:FRAC_W];
		if (shf[SHF_W-1:OUT_W-1] != {(SHF_W-OUT_W+1){shf[SHF_W-1]}})
			sum_d = shf[SHF_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
			                     : {1'b0, {(OUT_W-1){1'b1}}};
		else
			sum_d = shf[OUT_W-1:0];
	end

	// Sigmoid lookup over [-8, 8); index is bits [15:8] of sum + 8.0
	assign sig_idx = {~sum_d[FRAC_W+3], sum_d[FRAC_W+2:FRAC_W-4]};
	assign sig_val = SIG_TABLE[sig_idx];

	always_comb begin
		if (act_mode == MODE_IDENTITY)
			act_d = sum_d;
		else if (sum_d < -(OUT_W'(8) <<< FRAC_W))
			act_d = '0;
		else if (sum_d >= (OUT_W'(8) <<< FRAC_W))
			act_d = OUT_W'(1) <<< FRAC_W;
		else
			act_d = OUT_W'(sig_val);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid_q) begin
			sum_q <= sum_d;
			act_q <= act_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign weighted_sum = sum_q;
	assign activation   = act_q;

endmodule
`default_nettype wire

/* hdl/neuron_weighted_sum_sigmoid.sv */
// Top level of the neuron: link stream in, weighted sum and activation out.
`default_nettype none
// One neuron. Each transfer on the slave stream is one incoming link; the
// source value (Q4.12) times the weight (Q4.12) is accumulated in a
// saturating 40-bit accumulator, or for a bias link the weight alone. The
// transfer with tlast set closes the neuron and produces one master transfer
// carrying the sum rounded and saturated to Q12.12 and its activation:
// sigmoid from a 256-step table over [-8, 8) (mode 0) or identity (mode 1).
// Throughput is one link per clock, set by the single multiplier stage and
// the accumulate loop, as long as no closing link waits on a full final
// register. After the edge that accepts the last link loads the multiply
// stage, the term is written into the queue, accumulated into the final
// register, then rounded and looked up into the output register, which
// raises m_axis_tvalid. A four-entry queue between the multiplier and the
// accumulator lets the input keep streaming while a result waits to be taken.
// Write cfg_wdata with cfg_we only while no neuron is in flight.
module neuron_weighted_sum_sigmoid (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [15:0] source_value, [31:16] link_weight
	input  wire logic [0:0]  s_axis_tuser,   // [0] is_bias
	input  wire logic        s_axis_tlast,   // last_link
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [23:0] weighted_sum, [47:24] activation
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_wdata       // [0] activation_mode
);
	import nws_pkg::*;

	logic                     act_mode_q;
	logic                     fq_valid;
	logic                     fq_ready;
	link_term_t               fq_item;
	logic                     qb_valid;
	logic                     qb_ready;
	link_term_t               qb_item;
	logic signed [OUT_W-1:0]  sum_out;
	logic signed [OUT_W-1:0]  act_out;

	// Activation mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= MODE_SIGMOID;
		end else if (cfg_we) begin
			act_mode_q <= cfg_wdata[0];
		end
	end

	nws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.source_value (s_axis_tdata[VALUE_W-1:0]),
		.link_weight  (s_axis_tdata[2*VALUE_W-1:VALUE_W]),
		.is_bias      (s_axis_tuser[0]),
		.last_link    (s_axis_tlast),
		.term_valid   (fq_valid),
		.term_ready   (fq_ready),
		.term_item    (fq_item)
	);

	nws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	nws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.act_mode     (act_mode_q),
		.term_valid   (qb_valid),
		.term_ready   (qb_ready),
		.term_item    (qb_item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.weighted_sum (sum_out),
		.activation   (act_out)
	);

	assign m_axis_tdata = {act_out, sum_out};

endmodule
`default_nettype wire

/* tb/neuron_weighted_sum_sigmoid_test.sv */
// Self-checking testbench for the neuron weighted-sum and activation block.
`timescale 1ns / 1ps

module neuron_weighted_sum_sigmoid_test;
	import nws_pkg::*;

	// One expected result transfer
	typedef struct {
		logic signed [OUT_W-1:0] wsum;
		logic signed [OUT_W-1:0] act;
	} neuron_out_t;

	// Predicts each neuron's sum and activation and checks what comes out
	class neuron_checker;
		longint      running_sum;
		logic        mode;
		int          mismatches;
		int          sigmoid_lut [TABLE_N];
		neuron_out_t pending_outs [$];

		function new();
			bit [63:0] e;
			bit [63:0] d;
			bit [63:0] half [TABLE_N/2 + 1];
			running_sum = 0;
			mode = MODE_SIGMOID;
			mismatches = 0;
			// Logistic curve from repeated e^(-1/16) steps, mirrored for the negative half
			e = 64'd1 << 32;
			for (int k = 0; k <= TABLE_N / 2; k++) begin
				d = (64'd1 << 32) + e;
				half[k] = ((64'd1 << (FRAC_W + 32)) + (d >> 1)) / d;
				e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
			end
			for (int k = 0; k < TABLE_N; k++) begin
				if (k >= TABLE_N / 2)
					sigmoid_lut[k] = int'(half[k - TABLE_N/2]);
				else
					sigmoid_lut[k] = (1 << FRAC_W) - int'(half[TABLE_N/2 - k]);
			end
		endfunction

		function longint saturate(longint x, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -(longint'(1) <<< (bits - 1));
			if (x > hi)
				return hi;
			if (x < lo)
				return lo;
			return x;
		endfunction

		function longint sigmoid_of(longint x);
			longint span;
			span = longint'(8) <<< FRAC_W;
			if (x < -span)
				return 0;
			if (x >= span)
				return longint'(1) <<< FRAC_W;
			return sigmoid_lut[((x + span) >>> (FRAC_W - 4)) & (TABLE_N - 1)];
		endfunction

		// Accumulate one accepted link; a closing link queues the neuron's result
		function void note_link(logic signed [VALUE_W-1:0] src, logic signed [VALUE_W-1:0] wgt,
				logic bias, logic last);
			longint      term;
			longint      rounded;
			longint      act;
			neuron_out_t res;
			term = bias ? (longint'(wgt) <<< FRAC_W) : longint'(src) * longint'(wgt);
			running_sum = saturate(running_sum + term, ACC_W);
			if (!last)
				return;
			rounded = saturate((running_sum + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, OUT_W);
			act = (mode == MODE_IDENTITY) ? rounded : sigmoid_of(rounded);
			res.wsum = rounded[OUT_W-1:0];
			res.act = act[OUT_W-1:0];
			pending_outs.push_back(res);
			running_sum = 0;
		endfunction

		function void check_result(logic [2*OUT_W-1:0] data);
			neuron_out_t exp_out;
			logic signed [OUT_W-1:0] got_sum;
			logic signed [OUT_W-1:0] got_act;
			got_sum = data[OUT_W-1:0];
			got_act = data[2*OUT_W-1:OUT_W];
			if (pending_outs.size() == 0) begin
				$display("%0t: unexpected result, expected none, got sum %0d act %0d",
					$time, got_sum, got_act);
				mismatches++;
				return;
			end
			exp_out = pending_outs.pop_front();
			if (got_sum !== exp_out.wsum) begin
				$display("%0t: weighted_sum expected %0d got %0d", $time, exp_out.wsum, got_sum);
				mismatches++;
			end
			if (got_act !== exp_out.act) begin
				$display("%0t: activation expected %0d got %0d", $time, exp_out.act, got_act);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_outs.size();
		endfunction

		function void report_leftovers();
			if (pending_outs.size() != 0) begin
				$display("%0t: %0d results expected, got none", $time, pending_outs.size());
				mismatches += pending_outs.size();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [15:0] source_value, [31:16] link_weight
	logic [0:0]  s_axis_tuser = '0;   // [0] is_bias
	logic        s_axis_tlast = 1'b0; // last_link
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [23:0] weighted_sum, [47:24] activation
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_wdata = '0;      // [0] activation_mode

	bit            calm = 1'b0;
	neuron_checker sb = new();

	neuron_weighted_sum_sigmoid dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random stall decision, off during a calm stretch
	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 12);
	endfunction

	// Result side backpressure
	always @(posedge clk) begin
		m_axis_tready <= !take_break();
	end

	// Check results first, then note links: a result never comes from this edge's link
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_link(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser[0], s_axis_tlast);
	end

	task automatic send_link(input logic [15:0] src, input logic [15:0] wgt,
			input logic bias, input logic last);
		while (take_break()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {wgt, src};
		s_axis_tuser <= bias;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Block idle: no link offered, every result back, pipeline flushed
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		// Let the last accepted link be noted before counting what is pending
		@(posedge clk);
		for (int i = 0; i < 4000 && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	// kind 0: full range, 1: within +-1.0 so sums land in the table, 2: corner values
	function automatic logic [15:0] pick_value(int kind);
		if (kind == 0)
			return 16'($urandom_range(0, 65535));
		if (kind == 1)
			return 16'($urandom_range(0, 8192) - 4096);
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'h0001;
		endcase
	endfunction

	task automatic send_neuron(input int n_links);
		int kind;
		kind = ($urandom_range(9) < 5) ? 1 : ($urandom_range(1) ? 0 : 2);
		for (int i = 0; i < n_links; i++)
			send_link(pick_value(kind), pick_value(kind), $urandom_range(3) == 0,
				i == n_links - 1);
	endtask

	// Enough full-scale products to pin the accumulator at one of its rails
	task automatic send_long_neuron();
		logic [15:0] wgt;
		wgt = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		for (int i = 0; i < 520; i++)
			send_link(16'h8000, wgt, (i % 97) == 5, i == 519);
	endtask

	task automatic run_phase(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			send_neuron(len);
			sent += len;
		end
	endtask

	task automatic run_directed();
		// Corner products
		send_link(16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
		send_link(16'h8000, 16'h8000, 1'b0, 1'b1);
		send_link(16'h8000, 16'h7FFF, 1'b0, 1'b1);
		send_link(16'h0000, 16'h0000, 1'b0, 1'b1);
		// Bias link with a nonzero source that must be ignored
		send_link(16'h5A5A, 16'h1000, 1'b1, 1'b1);
		// Round half up on ties, both signs
		send_link(16'h0001, 16'h0800, 1'b0, 1'b1);
		send_link(16'hFFFF, 16'h0800, 1'b0, 1'b1);
		send_link(16'hFFFD, 16'h0800, 1'b0, 1'b1);
		// Exactly -8.0, then just below the table
		send_link(16'hA5A5, 16'h8000, 1'b1, 1'b1);
		send_link(16'h0000, 16'h8000, 1'b1, 1'b0);
		send_link(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		// Just under 8.0, then 8.0 reaching the top of the table
		send_link(16'h0000, 16'h7FFF, 1'b1, 1'b1);
		send_link(16'h0000, 16'h7FFF, 1'b1, 1'b0);
		send_link(16'h1234, 16'h0001, 1'b1, 1'b1);
		// Mixed multi-link neuron
		send_link(16'h0800, 16'h0800, 1'b0, 1'b0);
		send_link(16'h04D2, 16'hFCF7, 1'b1, 1'b0);
		send_link(16'hB1E0, 16'h012C, 1'b0, 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(MODE_SIGMOID);
		run_directed();
		// Random phases alternate the mode; one runs without any stalls
		for (int p = 0; p < 4; p++) begin
			settle();
			write_mode((p % 2 == 0) ? MODE_IDENTITY : MODE_SIGMOID);
			calm = (p == 2);
			// One rail-pinning neuron in each mode
			if (p < 2)
				send_long_neuron();
			run_phase(170);
		end
		calm = 1'b0;
		settle();
		sb.report_leftovers();
		if (sb.mismatches == 0)
			$display("PASS neuron_weighted_sum_sigmoid");
		else
			$display("FAIL neuron_weighted_sum_sigmoid");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("FAIL neuron_weighted_sum_sigmoid");
		$finish;
	end

endmodule
